FILE: hdl/dmg_pkg.sv
// ============================================================================
// dmg_pkg
// Shared types and codes for the damage rectangle table: op, result kind and
// add outcome codes, register indexes, the stored rectangle and the command
// record passed from the front end to the table sequencer.
// ============================================================================
`default_nettype none

package dmg_pkg;

    localparam int unsigned COORD_W      = 14;
    localparam int unsigned EDGE_W       = 16;
    localparam int unsigned CMD_Q_DEPTH  = 2;
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_MARK_FULL = 2'd1,
        OP_PUBLISH   = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_FULL = 2'd1,
        KIND_RECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OUTCOME_IGNORED  = 2'd0,
        OUTCOME_MERGED   = 2'd1,
        OUTCOME_APPENDED = 2'd2,
        OUTCOME_OVERFLOW = 2'd3
    } outcome_t;

    // Register indexes (address bit 2 selects the register).
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
    } rect_t;

    typedef struct packed {
        op_t   op;
        logic  empty;   // clipped rectangle has no area
        rect_t rect;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/dmg_front.sv
// ============================================================================
// dmg_front
// Input side: accepts transactions, clips the add rectangle to the frame and
// pushes a classified command into the command queue.
// ============================================================================
`default_nettype none

module dmg_front (
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_op,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]  s_left_edge,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]  s_top_edge,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]  s_right_edge,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]  s_bottom_edge,
    input  wire logic [dmg_pkg::COORD_W-1:0]        frame_width,
    input  wire logic [dmg_pkg::COORD_W-1:0]        frame_height,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output dmg_pkg::cmd_t                           q_data
);

    logic signed [dmg_pkg::EDGE_W-1:0] fw_s;
    logic signed [dmg_pkg::EDGE_W-1:0] fh_s;
    logic signed [dmg_pkg::EDGE_W-1:0] x0;
    logic signed [dmg_pkg::EDGE_W-1:0] y0;
    logic signed [dmg_pkg::EDGE_W-1:0] x1;
    logic signed [dmg_pkg::EDGE_W-1:0] y1;

    assign fw_s = $signed({{(dmg_pkg::EDGE_W-dmg_pkg::COORD_W){1'b0}}, frame_width});
    assign fh_s = $signed({{(dmg_pkg::EDGE_W-dmg_pkg::COORD_W){1'b0}}, frame_height});

    // Start edges clip at zero, end edges at the frame size.
    assign x0 = s_left_edge[dmg_pkg::EDGE_W-1]  ? '0 : s_left_edge;
    assign y0 = s_top_edge[dmg_pkg::EDGE_W-1]   ? '0 : s_top_edge;
    assign x1 = (s_right_edge  > fw_s) ? fw_s : s_right_edge;
    assign y1 = (s_bottom_edge > fh_s) ? fh_s : s_bottom_edge;

    // A non-empty clipped rectangle always lies within 0..16383, so the low
    // bits carry it exactly.
    always_comb begin
        q_data.op      = dmg_pkg::op_t'(s_op);
        q_data.empty   = (x1 <= x0) || (y1 <= y0);
        q_data.rect.x0 = x0[dmg_pkg::COORD_W-1:0];
        q_data.rect.y0 = y0[dmg_pkg::COORD_W-1:0];
        q_data.rect.x1 = x1[dmg_pkg::COORD_W-1:0];
        q_data.rect.y1 = y1[dmg_pkg::COORD_W-1:0];
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

`default_nettype wire

FILE: hdl/dmg_cmd_fifo.sv
// ============================================================================
// dmg_cmd_fifo
// Short command queue between the front end and the table sequencer.
// ============================================================================
`default_nettype none

module dmg_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire dmg_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output dmg_pkg::cmd_t      pop_data,
    output logic               empty
);

    localparam int unsigned PTR_W = (dmg_pkg::CMD_Q_DEPTH > 1) ?
                                    $clog2(dmg_pkg::CMD_Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(dmg_pkg::CMD_Q_DEPTH + 1);

    dmg_pkg::cmd_t    entry_reg [dmg_pkg::CMD_Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(dmg_pkg::CMD_Q_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full     = (cnt_reg == CNT_W'(dmg_pkg::CMD_Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = (push && !full) ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = (pop && !empty) ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dmg_back.sv
// ============================================================================
// dmg_back
// Table sequencer: holds the rectangle memory, walks it one entry per cycle
// for adds and unstalled publishes, and drives the result output register.
// ============================================================================
`default_nettype none

module dmg_back #(
    parameter int unsigned MAX_RECTS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_empty,
    input  wire dmg_pkg::cmd_t                 q_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_kind,
    output logic [1:0]                         m_add_outcome,
    output logic [dmg_pkg::COORD_W-1:0]        m_out_left,
    output logic [dmg_pkg::COORD_W-1:0]        m_out_top,
    output logic [dmg_pkg::COORD_W-1:0]        m_out_right,
    output logic [dmg_pkg::COORD_W-1:0]        m_out_bottom,
    output logic                               m_last
);

    localparam int unsigned IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACK,
        ST_PUB
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      full_reg, full_next;
    dmg_pkg::rect_t            rect_reg, rect_next;
    dmg_pkg::kind_t            kind_reg, kind_next;
    dmg_pkg::outcome_t         outcome_reg, outcome_next;

    logic                      m_valid_reg, m_valid_next;
    dmg_pkg::kind_t            m_kind_reg, m_kind_next;
    dmg_pkg::outcome_t         m_outcome_reg, m_outcome_next;
    dmg_pkg::rect_t            m_rect_reg, m_rect_next;
    logic                      m_last_reg, m_last_next;

    dmg_pkg::rect_t            mem [MAX_RECTS];
    dmg_pkg::rect_t            mem_q;
    logic [IDX_W-1:0]          rd_addr;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    dmg_pkg::rect_t            mem_wdata;

    logic                      out_free;
    logic                      touch;
    logic                      at_end;
    dmg_pkg::rect_t            merged;

    assign out_free = !m_valid_reg || m_ready;
    assign at_end   = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    // Edges that only meet still count as touching.
    assign touch = (mem_q.x0 <= rect_reg.x1) && (rect_reg.x0 <= mem_q.x1) &&
                   (mem_q.y0 <= rect_reg.y1) && (rect_reg.y0 <= mem_q.y1);

    always_comb begin
        merged.x0 = (rect_reg.x0 < mem_q.x0) ? rect_reg.x0 : mem_q.x0;
        merged.y0 = (rect_reg.y0 < mem_q.y0) ? rect_reg.y0 : mem_q.y0;
        merged.x1 = (rect_reg.x1 > mem_q.x1) ? rect_reg.x1 : mem_q.x1;
        merged.y1 = (rect_reg.y1 > mem_q.y1) ? rect_reg.y1 : mem_q.y1;
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        full_next      = full_reg;
        rect_next      = rect_reg;
        kind_next      = kind_reg;
        outcome_next   = outcome_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_outcome_next = m_outcome_reg;
        m_rect_next    = m_rect_reg;
        m_last_next    = m_last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rect_reg;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop        = 1'b1;
                    idx_next     = '0;
                    rect_next    = q_data.rect;
                    kind_next    = dmg_pkg::KIND_ACK;
                    outcome_next = dmg_pkg::OUTCOME_IGNORED;
                    state_next   = ST_ACK;
                    unique case (q_data.op)
                        dmg_pkg::OP_ADD: begin
                            if (!full_reg && !q_data.empty) begin
                                if (cnt_reg == '0) begin
                                    mem_we       = 1'b1;
                                    mem_waddr    = '0;
                                    mem_wdata    = q_data.rect;
                                    cnt_next     = CNT_W'(1);
                                    outcome_next = dmg_pkg::OUTCOME_APPENDED;
                                end else begin
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        dmg_pkg::OP_MARK_FULL: begin
                            full_next = 1'b1;
                            cnt_next  = '0;
                        end
                        dmg_pkg::OP_PUBLISH: begin
                            if (full_reg || cnt_reg == '0) begin
                                kind_next = dmg_pkg::KIND_FULL;
                            end else begin
                                state_next = ST_PUB;
                            end
                        end
                        dmg_pkg::OP_CLEAR: begin
                            full_next = 1'b0;
                            cnt_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                rd_addr = idx_reg + IDX_W'(1);
                if (touch) begin
                    mem_we       = 1'b1;
                    mem_waddr    = idx_reg;
                    mem_wdata    = merged;
                    outcome_next = dmg_pkg::OUTCOME_MERGED;
                    state_next   = ST_ACK;
                end else if (at_end) begin
                    state_next = ST_ACK;
                    if (cnt_reg == CNT_W'(MAX_RECTS)) begin
                        full_next    = 1'b1;
                        cnt_next     = '0;
                        outcome_next = dmg_pkg::OUTCOME_OVERFLOW;
                    end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = cnt_reg[IDX_W-1:0];
                        mem_wdata    = rect_reg;
                        cnt_next     = cnt_reg + CNT_W'(1);
                        outcome_next = dmg_pkg::OUTCOME_APPENDED;
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_ACK: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = kind_reg;
                    m_outcome_next = outcome_reg;
                    m_rect_next    = '0;
                    m_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_PUB: begin
                // Re-read the current entry while the output stalls.
                rd_addr = out_free ? idx_reg + IDX_W'(1) : idx_reg;
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = dmg_pkg::KIND_RECT;
                    m_outcome_next = dmg_pkg::OUTCOME_IGNORED;
                    m_rect_next    = mem_q;
                    m_last_next    = at_end;
                    if (at_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            full_reg    <= full_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg       <= idx_next;
        rect_reg      <= rect_next;
        kind_reg      <= kind_next;
        outcome_reg   <= outcome_next;
        m_kind_reg    <= m_kind_next;
        m_outcome_reg <= m_outcome_next;
        m_rect_reg    <= m_rect_next;
        m_last_reg    <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[rd_addr];
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_add_outcome = m_outcome_reg;
    assign m_out_left    = m_rect_reg.x0;
    assign m_out_top     = m_rect_reg.y0;
    assign m_out_right   = m_rect_reg.x1;
    assign m_out_bottom  = m_rect_reg.y1;
    assign m_last        = m_last_reg;

    // The table never holds more rectangles than it has room for.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RECTS))
        else $error("rectangle count exceeds table size");

    // Full-frame mode always comes with an empty table.
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (cnt_reg == '0))
        else $error("full-frame mode with rectangles stored");

    // A scan or a publish walk stays below the fill count.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_PUB) |->
            (CNT_W'(idx_reg) < cnt_reg))
        else $error("table walk past the last stored rectangle");

    // Anything but a published rectangle is a single, final result.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg != dmg_pkg::KIND_RECT) |-> m_last_reg)
        else $error("acknowledgement without last");

endmodule

`default_nettype wire

FILE: hdl/damage_rect_merge_table.sv
// With the block idle, an accepted transaction is queued, popped by the sequencer and answered
// through the result output register; an add first checks the n stored rectangles (at most
// MAX_RECTS), and publish streams one rectangle per cycle after its first while m_ready does
// not stall the output. The table walk visits one entry per cycle, unless a publish is held by
// the output, through the single read port of the rectangle memory. Reset (aresetn low,
// synchronous) empties the table, leaves full-frame mode and zeroes both frame size registers.
// ============================================================================
// damage_rect_merge_table
// Screen damage tracker. Incoming add, mark-full, publish and clear
// transactions are clipped and queued by the front end, then carried out by
// a sequencer that keeps up to MAX_RECTS bounding boxes in a small memory.
// ============================================================================
`default_nettype none

module damage_rect_merge_table #(
    parameter int unsigned MAX_RECTS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dmg_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [dmg_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dmg_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready,

    // Command channel.
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_op,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]   s_left_edge,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]   s_top_edge,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]   s_right_edge,
    input  wire logic signed [dmg_pkg::EDGE_W-1:0]   s_bottom_edge,

    // Result channel.
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [1:0]                               m_kind,
    output logic [1:0]                               m_add_outcome,
    output logic [dmg_pkg::COORD_W-1:0]              m_out_left,
    output logic [dmg_pkg::COORD_W-1:0]              m_out_top,
    output logic [dmg_pkg::COORD_W-1:0]              m_out_right,
    output logic [dmg_pkg::COORD_W-1:0]              m_out_bottom,
    output logic                                     m_last
);

    // Frame size registers. Bit 2 of the address picks the register; the
    // low address bits are not decoded.
    logic [dmg_pkg::COORD_W-1:0] frame_width_reg, frame_width_next;
    logic [dmg_pkg::COORD_W-1:0] frame_height_reg, frame_height_next;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                dmg_pkg::REG_FRAME_WIDTH:  frame_width_next  = pwdata[dmg_pkg::COORD_W-1:0];
                dmg_pkg::REG_FRAME_HEIGHT: frame_height_next = pwdata[dmg_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            dmg_pkg::REG_FRAME_WIDTH:
                prdata = {{(dmg_pkg::APB_DATA_W-dmg_pkg::COORD_W){1'b0}}, frame_width_reg};
            dmg_pkg::REG_FRAME_HEIGHT:
                prdata = {{(dmg_pkg::APB_DATA_W-dmg_pkg::COORD_W){1'b0}}, frame_height_reg};
            default:
                prdata = '0;
        endcase
    end

    // The front end clips each accepted transaction against the current
    // frame size and queues it. The user must change configuration only while
    // the block is idle; the block does not enforce it. Then clipping at
    // acceptance gives the same answer as clipping when the command is carried out.
    dmg_pkg::cmd_t q_in_data;
    dmg_pkg::cmd_t q_out_data;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    dmg_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_left_edge   (s_left_edge),
        .s_top_edge    (s_top_edge),
        .s_right_edge  (s_right_edge),
        .s_bottom_edge (s_bottom_edge),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in_data)
    );

    // The command queue lets the front end keep taking transactions while
    // the sequencer is busy walking the table.
    dmg_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out_data),
        .empty     (q_empty)
    );

    // The sequencer owns the rectangle memory, the fill count, full-frame
    // mode and the result output register, so a stalled result never blocks
    // the queue from filling.
    dmg_back #(
        .MAX_RECTS (MAX_RECTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (q_out_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_add_outcome (m_add_outcome),
        .m_out_left    (m_out_left),
        .m_out_top     (m_out_top),
        .m_out_right   (m_out_right),
        .m_out_bottom  (m_out_bottom),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
